[src/hpm_pkg.sv]
// Package for the homography point mapper: formats, widths, register indexes
// and the structs passed between pipeline modules. No dependencies.
package hpm_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COEF_FRAC_BITS  = 24;

  localparam int WORD_W   = 32;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int CONST_W  = WORD_W + COORD_FRAC_BITS;
  localparam int SUM_W    = PROD_W + 2;
  localparam int NUM_W    = SUM_W + COORD_FRAC_BITS + 2;
  localparam int QBITS    = WORD_W;
  localparam int DS_W     = SUM_W + QBITS;
  localparam int CMP_W    = DS_W + 1;
  localparam int DIV_STAGES = QBITS;

  localparam logic [WORD_W-1:0] COEF22_RESET = WORD_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic [WORD_W-1:0] POS_LIMIT    = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_LIMIT    = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_ROW0_A      = 3'd0,
    REG_ROW0B_ROW1A = 3'd1,
    REG_ROW1_B      = 3'd2,
    REG_ROW2_A      = 3'd3,
    REG_ROW2_C      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] h00;
    logic signed [WORD_W-1:0] h01;
    logic signed [WORD_W-1:0] h02;
    logic signed [WORD_W-1:0] h10;
    logic signed [WORD_W-1:0] h11;
    logic signed [WORD_W-1:0] h12;
    logic signed [WORD_W-1:0] h20;
    logic signed [WORD_W-1:0] h21;
    logic signed [WORD_W-1:0] h22;
  } coef_t;

  // One item inside the divider: partial remainders, shifted divisor,
  // quotient bits so far and the flags decided up front.
  typedef struct packed {
    logic [NUM_W-1:0]  rem_x;
    logic [NUM_W-1:0]  rem_y;
    logic [DS_W-1:0]   dsor;
    logic [QBITS-1:0]  q_x;
    logic [QBITS-1:0]  q_y;
    logic              neg_x;
    logic              neg_y;
    logic              ovf_x;
    logic              ovf_y;
    logic              zero;
  } div_t;

endpackage

[src/hpm_front.sv]
// Front end of the mapper: products, row sums, magnitudes and divider setup.
// Three register stages. Depends on hpm_pkg.
module hpm_front import hpm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  coef_t                    coef,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [WORD_W-1:0] in_src_x,
  input  logic signed [WORD_W-1:0] in_src_y,
  input  logic                     down_en,
  output logic                     out_vld,
  output div_t                     out_data
);

  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;

  logic signed [PROD_W-1:0] p00_r, p01_r, p10_r, p11_r, p20_r, p21_r;
  logic signed [SUM_W-1:0]  u_r, v_r, w_r;
  logic signed [SUM_W-1:0]  u_nxt, v_nxt, w_nxt;
  div_t                     d3_r, d3_nxt;

  logic [SUM_W-1:0]  au, av, aw;
  logic [NUM_W-1:0]  n2_x, n2_y;
  logic [CMP_W-1:0]  d2_top;

  // Stage enables: a stage moves when empty or when its successor moves
  assign en3      = !v3_r || down_en;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Stage 1: the six coordinate products
  always_ff @(posedge clk) begin
    if (en1) begin
      p00_r <= coef.h00 * in_src_x;
      p01_r <= coef.h01 * in_src_y;
      p10_r <= coef.h10 * in_src_x;
      p11_r <= coef.h11 * in_src_y;
      p20_r <= coef.h20 * in_src_x;
      p21_r <= coef.h21 * in_src_y;
    end
  end

  // Stage 2: row sums with the constant column scaled to product format
  always_comb begin
    u_nxt = SUM_W'(p00_r) + SUM_W'(p01_r)
          + SUM_W'(CONST_W'(coef.h02) <<< COORD_FRAC_BITS);
    v_nxt = SUM_W'(p10_r) + SUM_W'(p11_r)
          + SUM_W'(CONST_W'(coef.h12) <<< COORD_FRAC_BITS);
    w_nxt = SUM_W'(p20_r) + SUM_W'(p21_r)
          + SUM_W'(CONST_W'(coef.h22) <<< COORD_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      w_r <= w_nxt;
    end
  end

  // Stage 3: magnitudes, rounding numerators, overflow pre-check
  always_comb begin
    au = u_r[SUM_W-1] ? SUM_W'(-u_r) : SUM_W'(u_r);
    av = v_r[SUM_W-1] ? SUM_W'(-v_r) : SUM_W'(v_r);
    aw = w_r[SUM_W-1] ? SUM_W'(-w_r) : SUM_W'(w_r);
    // 2*|u|*2^frac + |w| over 2*|w| gives round half away from zero
    n2_x   = NUM_W'({au, (COORD_FRAC_BITS + 1)'(0)}) + NUM_W'(aw);
    n2_y   = NUM_W'({av, (COORD_FRAC_BITS + 1)'(0)}) + NUM_W'(aw);
    d2_top = CMP_W'({aw, 1'b0}) << QBITS;

    d3_nxt.rem_x = n2_x;
    d3_nxt.rem_y = n2_y;
    d3_nxt.dsor  = DS_W'({aw, 1'b0}) << (QBITS - 1);
    d3_nxt.q_x   = '0;
    d3_nxt.q_y   = '0;
    d3_nxt.neg_x = u_r[SUM_W-1] ^ w_r[SUM_W-1];
    d3_nxt.neg_y = v_r[SUM_W-1] ^ w_r[SUM_W-1];
    d3_nxt.ovf_x = CMP_W'(n2_x) >= d2_top;
    d3_nxt.ovf_y = CMP_W'(n2_y) >= d2_top;
    d3_nxt.zero  = (w_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en3) d3_r <= d3_nxt;
  end

  assign out_vld  = v3_r;
  assign out_data = d3_r;

endmodule

[src/hpm_div_stage.sv]
// One restoring-division step for both quotient lanes (one bit per lane).
// Depends on hpm_pkg.
module hpm_div_stage import hpm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_vld,
  input  div_t up_data,
  input  logic down_en,
  output logic en,
  output logic out_vld,
  output div_t out_data
);

  logic vld_r;
  div_t data_r, data_nxt;
  logic ge_x, ge_y;

  assign en = !vld_r || down_en;

  // Compare against the shifted divisor, subtract on success, shift in the bit
  always_comb begin
    data_nxt = up_data;
    ge_x = DS_W'(up_data.rem_x) >= up_data.dsor;
    ge_y = DS_W'(up_data.rem_y) >= up_data.dsor;
    if (ge_x) data_nxt.rem_x = NUM_W'(DS_W'(up_data.rem_x) - up_data.dsor);
    if (ge_y) data_nxt.rem_y = NUM_W'(DS_W'(up_data.rem_y) - up_data.dsor);
    data_nxt.q_x  = {up_data.q_x[QBITS-2:0], ge_x};
    data_nxt.q_y  = {up_data.q_y[QBITS-2:0], ge_y};
    data_nxt.dsor = up_data.dsor >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

[src/homography_point_mapper_unit.sv]
// Top level of the homography point mapper: coefficient registers, front end,
// divider pipeline and output register. Depends on hpm_pkg, hpm_front, hpm_div_stage.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_ready  | in_src_x, in_src_y
//   out      | out_valid / out_ready| out_dst_x, out_dst_y, out_zero_divisor,
//            |                      | out_saturated
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One point per cycle sustained while out_ready is held; 3 front stages, 32
// divider steps at one quotient bit each, one output stage.
// Reset clears all valid bits and loads the identity-scale h22, others zero.
// Each stage fills when empty, so bubbles are squeezed out under a stall and
// the ready chain runs back from out_ready through the stage enables.
module homography_point_mapper_unit import hpm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [WORD_W-1:0] in_src_x,
  input  logic signed [WORD_W-1:0] in_src_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_dst_x,
  output logic signed [WORD_W-1:0] out_dst_y,
  output logic                     out_zero_divisor,
  output logic                     out_saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [2*WORD_W-1:0]      cfg_data
);

  coef_t coef_r;

  logic  vld  [DIV_STAGES+1];
  div_t  dat  [DIV_STAGES+1];
  logic  sen  [DIV_STAGES+1];

  logic  out_en;
  logic  out_valid_r;
  logic signed [WORD_W-1:0] dst_x_r, dst_y_r, dst_x_nxt, dst_y_nxt;
  logic  zero_r, sat_r, sat_nxt;
  logic [WORD_W-1:0] lim_x, lim_y, mag_x, mag_y;
  logic  over_x, over_y;

  // Coefficient registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '{h22: COEF22_RESET, default: '0};
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW0_A: begin
          coef_r.h00 <= cfg_data[2*WORD_W-1:WORD_W];
          coef_r.h01 <= cfg_data[WORD_W-1:0];
        end
        REG_ROW0B_ROW1A: begin
          coef_r.h02 <= cfg_data[2*WORD_W-1:WORD_W];
          coef_r.h10 <= cfg_data[WORD_W-1:0];
        end
        REG_ROW1_B: begin
          coef_r.h11 <= cfg_data[2*WORD_W-1:WORD_W];
          coef_r.h12 <= cfg_data[WORD_W-1:0];
        end
        REG_ROW2_A: begin
          coef_r.h20 <= cfg_data[2*WORD_W-1:WORD_W];
          coef_r.h21 <= cfg_data[WORD_W-1:0];
        end
        REG_ROW2_C: begin
          coef_r.h22 <= cfg_data[WORD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  hpm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_src_x (in_src_x),
    .in_src_y (in_src_y),
    .down_en  (sen[0]),
    .out_vld  (vld[0]),
    .out_data (dat[0])
  );

  // Divider chain, one quotient bit per stage
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    hpm_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_vld   (vld[i]),
      .up_data  (dat[i]),
      .down_en  (sen[i+1]),
      .en       (sen[i]),
      .out_vld  (vld[i+1]),
      .out_data (dat[i+1])
    );
  end

  assign out_en           = !out_valid_r || out_ready;
  assign sen[DIV_STAGES]  = out_en;

  // Apply sign, clamp to range, and zero out on a zero divisor
  always_comb begin
    lim_x  = dat[DIV_STAGES].neg_x ? NEG_LIMIT : POS_LIMIT;
    lim_y  = dat[DIV_STAGES].neg_y ? NEG_LIMIT : POS_LIMIT;
    over_x = dat[DIV_STAGES].ovf_x || (dat[DIV_STAGES].q_x > lim_x);
    over_y = dat[DIV_STAGES].ovf_y || (dat[DIV_STAGES].q_y > lim_y);
    mag_x  = over_x ? lim_x : dat[DIV_STAGES].q_x;
    mag_y  = over_y ? lim_y : dat[DIV_STAGES].q_y;
    dst_x_nxt = dat[DIV_STAGES].neg_x ? -$signed(mag_x) : $signed(mag_x);
    dst_y_nxt = dat[DIV_STAGES].neg_y ? -$signed(mag_y) : $signed(mag_y);
    sat_nxt   = over_x || over_y;
    if (dat[DIV_STAGES].zero) begin
      dst_x_nxt = '0;
      dst_y_nxt = '0;
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      dst_x_r <= dst_x_nxt;
      dst_y_r <= dst_y_nxt;
      zero_r  <= dat[DIV_STAGES].zero;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dst_x        = dst_x_r;
  assign out_dst_y        = dst_y_r;
  assign out_zero_divisor = zero_r;
  assign out_saturated    = sat_r;

endmodule

[src/hpm_checker.sv]
// Port-level checks for the homography point mapper, bound to the top level.
// Depends on hpm_pkg and homography_point_mapper_unit.
module hpm_checker import hpm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] out_dst_x,
  input logic signed [WORD_W-1:0] out_dst_y,
  input logic                     out_zero_divisor,
  input logic                     out_saturated,
  input logic                     cfg_ready
);

  // A zero divisor never reports saturation
  a_zero_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_divisor |-> !out_saturated)
    else $error("saturated set together with zero_divisor");

  // A zero divisor gives zero coordinates
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_divisor |-> out_dst_x == '0 && out_dst_y == '0)
    else $error("nonzero result on zero divisor");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dst_x) && $stable(out_dst_y))
    else $error("result changed under stall");

  // Configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("cfg_ready dropped");

endmodule

bind homography_point_mapper_unit hpm_checker u_hpm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_dst_x        (out_dst_x),
  .out_dst_y        (out_dst_y),
  .out_zero_divisor (out_zero_divisor),
  .out_saturated    (out_saturated),
  .cfg_ready        (cfg_ready)
);
